// File: rtl/orient3d_filtered_predicate_top_macros.svh
// ----------------------------------------------------------------------------
// orient3d_filtered_predicate_top_macros
// Assertion macros for the orientation predicate block. Define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ORIENT3D_FILTERED_PREDICATE_TOP_MACROS_SVH
`define ORIENT3D_FILTERED_PREDICATE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define O3D_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("o3d assertion failed: implication");

// next-cycle implication
`define O3D_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("o3d assertion failed: next-cycle implication");

`else

`define O3D_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define O3D_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// File: rtl/o3d_pkg.sv
// ----------------------------------------------------------------------------
// o3d_pkg
// Shared types and constants of the filtered 3D orientation predicate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package o3d_pkg;

  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned DET_W          = 56;
  localparam int unsigned SHIFT_W        = 6;
  localparam int unsigned ORIENT_W       = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd42;

  localparam logic signed [ORIENT_W-1:0] ORIENT_POS  = 2'sb01;
  localparam logic signed [ORIENT_W-1:0] ORIENT_ZERO = 2'sb00;
  localparam logic signed [ORIENT_W-1:0] ORIENT_NEG  = 2'sb11;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cz;
    logic signed [FIELD_W-1:0] dx;
    logic signed [FIELD_W-1:0] dy;
    logic signed [FIELD_W-1:0] dz;
  } in_item_t;

  typedef struct packed {
    logic signed [ORIENT_W-1:0] orientation;
    logic signed [DET_W-1:0]    determinant;
  } res_t;

endpackage

// File: rtl/orient3d_filtered_predicate_top.sv
// ----------------------------------------------------------------------------
// orient3d_filtered_predicate_top
// Filtered 3D orientation predicate: exact edge determinant of four points
// compared against a tolerance of (max axis extent)^3 >> tolerance_shift.
//
//   channel  signals                          direction  transfer when
//   input    start, busy, item_i              in         start && !busy
//   result   done_o, res_o                    out        done_o (no stall)
//   config   cfg_valid_i, cfg_ready_o,        in         cfg_valid_i &&
//            cfg_data_i                                  cfg_ready_o
//
// One item per cycle; the result transfers after the six register stages
// (diff, products, minors, row products, sum, compare). busy is high and
// cfg_ready_o low only while in reset.
// Reset clears the stage valid bits and loads tolerance_shift with 42.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "orient3d_filtered_predicate_top_macros.svh"

module orient3d_filtered_predicate_top #(
  parameter int unsigned COORD_BITS = o3d_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  o3d_pkg::in_item_t             item_i,
  output logic                          done_o,
  output o3d_pkg::res_t                 res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [o3d_pkg::SHIFT_W-1:0]   cfg_data_i
);

  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned CubeW = 3 * COORD_BITS;
  localparam int unsigned Lat   = 6;

  logic                               in_fire;
  logic                               cfg_fire;
  logic [Lat-2:0]                     vld_d, vld_q;
  logic                               done_d, done_q;
  logic [o3d_pkg::SHIFT_W-1:0]        shift_d, shift_q;
  logic signed [DiffW-1:0]            diff [3][3];
  logic        [COORD_BITS-1:0]       ext  [3];
  logic signed [o3d_pkg::DET_W-1:0]   det;
  logic        [CubeW-1:0]            tol;
  logic signed [o3d_pkg::DET_W-1:0]   tol_pos, tol_neg;
  o3d_pkg::res_t                      res_d, res_q;
  logic                               out_pos, out_neg;

  assign busy        = !rst_ni;
  assign cfg_ready_o = rst_ni;
  assign in_fire     = start && !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign shift_d = cfg_fire ? cfg_data_i : shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= o3d_pkg::SHIFT_RESET;
    end else begin
      shift_q <= shift_d;
    end
  end

  o3d_diff #(.CoordBits(COORD_BITS)) u_diff (
    .clk_i  (clk_i),
    .item_i (item_i),
    .diff_o (diff),
    .ext_o  (ext)
  );

  o3d_det #(.CoordBits(COORD_BITS)) u_det (
    .clk_i  (clk_i),
    .diff_i (diff),
    .det_o  (det)
  );

  o3d_tol #(.CoordBits(COORD_BITS)) u_tol (
    .clk_i   (clk_i),
    .ext_i   (ext),
    .shift_i (shift_q),
    .tol_o   (tol)
  );

  // stage valid bits, one per register stage ahead of the output
  assign vld_d  = {vld_q[Lat-3:0], in_fire};
  assign done_d = vld_q[Lat-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  assign tol_pos = o3d_pkg::DET_W'(tol);
  assign tol_neg = -tol_pos;

  always_comb begin
    res_d.determinant = det;
    if (det > tol_pos) begin
      res_d.orientation = o3d_pkg::ORIENT_POS;
    end else if (det < tol_neg) begin
      res_d.orientation = o3d_pkg::ORIENT_NEG;
    end else begin
      res_d.orientation = o3d_pkg::ORIENT_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  assign out_pos = done_o && (res_o.orientation == o3d_pkg::ORIENT_POS);
  assign out_neg = done_o && (res_o.orientation == o3d_pkg::ORIENT_NEG);

  `O3D_ASSERT_IMPL(a_done_latency, clk_i, rst_ni, done_o, $past(in_fire, Lat))
  `O3D_ASSERT_IMPL(a_pos_sign, clk_i, rst_ni, out_pos, res_o.determinant > 0)
  `O3D_ASSERT_IMPL(a_neg_sign, clk_i, rst_ni, out_neg, res_o.determinant < 0)
  `O3D_ASSERT_NEXT(a_cfg_write, clk_i, rst_ni, cfg_fire, shift_q == $past(cfg_data_i))

endmodule

// File: rtl/o3d_diff.sv
// ----------------------------------------------------------------------------
// o3d_diff
// Stage 1: narrows coordinates, forms edge vectors from the first point and
// the per-axis extent of the four points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module o3d_diff #(
  parameter int unsigned CoordBits = o3d_pkg::COORD_BITS_DEF,
  localparam int unsigned DiffW    = CoordBits + 1
) (
  input  logic                         clk_i,
  input  o3d_pkg::in_item_t            item_i,
  output logic signed [DiffW-1:0]      diff_o [3][3],
  output logic        [CoordBits-1:0]  ext_o  [3]
);

  logic signed [CoordBits-1:0] pt [4][3];
  logic signed [DiffW-1:0]     diff_d [3][3];
  logic        [CoordBits-1:0] ext_d  [3];
  logic signed [DiffW-1:0]     diff_q [3][3];
  logic        [CoordBits-1:0] ext_q  [3];

  always_comb begin
    pt[0][0] = item_i.ax[CoordBits-1:0];
    pt[0][1] = item_i.ay[CoordBits-1:0];
    pt[0][2] = item_i.az[CoordBits-1:0];
    pt[1][0] = item_i.bx[CoordBits-1:0];
    pt[1][1] = item_i.by[CoordBits-1:0];
    pt[1][2] = item_i.bz[CoordBits-1:0];
    pt[2][0] = item_i.cx[CoordBits-1:0];
    pt[2][1] = item_i.cy[CoordBits-1:0];
    pt[2][2] = item_i.cz[CoordBits-1:0];
    pt[3][0] = item_i.dx[CoordBits-1:0];
    pt[3][1] = item_i.dy[CoordBits-1:0];
    pt[3][2] = item_i.dz[CoordBits-1:0];
  end

  always_comb begin
    logic signed [CoordBits-1:0] hi01, hi23, lo01, lo23, hi, lo;
    logic signed [DiffW-1:0]     span;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        diff_d[i][k] = DiffW'(pt[i+1][k]) - DiffW'(pt[0][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      hi01 = (pt[1][k] > pt[0][k]) ? pt[1][k] : pt[0][k];
      lo01 = (pt[1][k] < pt[0][k]) ? pt[1][k] : pt[0][k];
      hi23 = (pt[3][k] > pt[2][k]) ? pt[3][k] : pt[2][k];
      lo23 = (pt[3][k] < pt[2][k]) ? pt[3][k] : pt[2][k];
      hi   = (hi23 > hi01) ? hi23 : hi01;
      lo   = (lo23 < lo01) ? lo23 : lo01;
      span = DiffW'(hi) - DiffW'(lo);
      ext_d[k] = span[CoordBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    ext_q  <= ext_d;
  end

  assign diff_o = diff_q;
  assign ext_o  = ext_q;

endmodule

// File: rtl/o3d_det.sv
// ----------------------------------------------------------------------------
// o3d_det
// Stages 2-5: exact 3x3 determinant of the edge vectors. Pair products,
// minors, row products and the final sum each take one register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module o3d_det #(
  parameter int unsigned CoordBits = o3d_pkg::COORD_BITS_DEF,
  localparam int unsigned DiffW    = CoordBits + 1
) (
  input  logic                               clk_i,
  input  logic signed [DiffW-1:0]            diff_i [3][3],
  output logic signed [o3d_pkg::DET_W-1:0]   det_o
);

  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned MinorW = ProdW + 1;
  localparam int unsigned TermW  = DiffW + MinorW;
  localparam int unsigned SumW   = TermW + 2;

  // index: [0] u = b-a, [1] v = c-a, [2] w = d-a; axis x, y, z
  logic signed [ProdW-1:0]  prod_q  [6];
  logic signed [DiffW-1:0]  lead2_q [3];
  logic signed [MinorW-1:0] minor_q [3];
  logic signed [DiffW-1:0]  lead3_q [3];
  logic signed [TermW-1:0]  term_q  [3];
  logic signed [SumW-1:0]   sum_d;
  logic signed [o3d_pkg::DET_W-1:0] det_q;

  always_ff @(posedge clk_i) begin
    prod_q[0] <= ProdW'(diff_i[1][1]) * ProdW'(diff_i[2][2]);
    prod_q[1] <= ProdW'(diff_i[2][1]) * ProdW'(diff_i[1][2]);
    prod_q[2] <= ProdW'(diff_i[2][1]) * ProdW'(diff_i[0][2]);
    prod_q[3] <= ProdW'(diff_i[0][1]) * ProdW'(diff_i[2][2]);
    prod_q[4] <= ProdW'(diff_i[0][1]) * ProdW'(diff_i[1][2]);
    prod_q[5] <= ProdW'(diff_i[1][1]) * ProdW'(diff_i[0][2]);
    for (int i = 0; i < 3; i++) begin
      lead2_q[i] <= diff_i[i][0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      minor_q[i] <= MinorW'(prod_q[2*i]) - MinorW'(prod_q[2*i+1]);
      lead3_q[i] <= lead2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      term_q[i] <= TermW'(lead3_q[i]) * TermW'(minor_q[i]);
    end
  end

  assign sum_d = SumW'(term_q[0]) + SumW'(term_q[1]) + SumW'(term_q[2]);

  always_ff @(posedge clk_i) begin
    det_q <= o3d_pkg::DET_W'(sum_d);
  end

  assign det_o = det_q;

endmodule

// File: rtl/o3d_tol.sv
// ----------------------------------------------------------------------------
// o3d_tol
// Stages 2-5: largest axis extent, its cube over two multiplies, then the
// configured right shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module o3d_tol #(
  parameter int unsigned CoordBits = o3d_pkg::COORD_BITS_DEF,
  localparam int unsigned CubeW    = 3 * CoordBits
) (
  input  logic                          clk_i,
  input  logic [CoordBits-1:0]          ext_i [3],
  input  logic [o3d_pkg::SHIFT_W-1:0]   shift_i,
  output logic [CubeW-1:0]              tol_o
);

  logic [CoordBits-1:0]   emax_d;
  logic [CoordBits-1:0]   e2_q;
  logic [CoordBits-1:0]   e3_q;
  logic [2*CoordBits-1:0] sq_q;
  logic [CubeW-1:0]       cube_q;
  logic [CubeW-1:0]       tol_q;

  always_comb begin
    emax_d = ext_i[0];
    if (ext_i[1] > emax_d) begin
      emax_d = ext_i[1];
    end
    if (ext_i[2] > emax_d) begin
      emax_d = ext_i[2];
    end
  end

  always_ff @(posedge clk_i) begin
    e2_q   <= emax_d;
    sq_q   <= (2*CoordBits)'(e2_q) * (2*CoordBits)'(e2_q);
    e3_q   <= e2_q;
    cube_q <= CubeW'(sq_q) * CubeW'(e3_q);
    tol_q  <= cube_q >> shift_i;
  end

  assign tol_o = tol_q;

endmodule
